@@ hdl/aarc_pkg.sv @@
// shared types and constants for the axis-angle rotation composer
`default_nettype none

package aarc_pkg;

  // quaternion parts and unit axes, signed Q30 with headroom
  localparam int QW = 34;
  // cordic datapath width
  localparam int AW = 36;

  localparam logic signed [QW-1:0] ONE_Q30     = 34'sh040000000;
  localparam logic signed [AW-1:0] GAIN_Q30    = 36'sh026DD3B6A;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sh06487ED51;
  localparam logic signed [AW-1:0] PI_Q30      = 36'sh0C90FDAA2;

  // arctangent of 2^-i, Q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_e;

  typedef struct packed {
    logic         load;
    cordic_mode_e mode;
  } cordic_cmd_t;

endpackage

`default_nettype wire

@@ hdl/axis_angle_rotation_composer.sv @@
// top level: composes the held axis-angle rotation with each incoming increment
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: step axis x, y, z, step angle
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: new axis x, y, z, new angle;
//           |     |                              | tuser: bad_axis
//
// each item runs, in order: normalize the held axis (square, check, root steps, three
// quotients), cordic sin/cos and scaling of its half angle; the same for the step; the
// quaternion mac; normalize the product; a cordic atan run; then the result is posted and
// the sequencer is idle again before the next transfer. a zero step axis skips its root,
// quotients, cordic run and scaling; a zero product axis skips root, quotients and atan.
// s_axis_tready is high only while idle; a finished result sits in the output register
// and the next transfer is taken while it waits for m_axis_tready; a new result waits
// in the done state until the output register is free.
// reset loads the held rotation with axis (0,0,1) and angle 0.
`default_nettype none

module axis_angle_rotation_composer import aarc_pkg::*; #(
  parameter int CORDIC_STEPS   = 16,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // step_axis_x, step_axis_y, step_axis_z, step_angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // new_axis_x, new_axis_y, new_axis_z, new_angle
  output logic [0:0]       m_axis_tuser    // bad_axis
);

  typedef enum logic [3:0] {
    S_IDLE, S_NSQ, S_NCHK, S_NSQRT, S_NDIV_GO, S_NDIV_WAIT, S_TRIG, S_TRIG_WAIT,
    S_SCL, S_HAM, S_ATAN, S_ATAN_WAIT, S_DONE
  } state_e;

  // which vector the shared normalize path is working on
  typedef enum logic [1:0] {
    P_CUR, P_STEP, P_OUT
  } pass_e;

  typedef struct packed {
    logic [1:0] i1;
    logic [1:0] i2;
    logic       neg;
  } ham_t;

  // unit z of the degenerate result, saturated to 16 bits
  localparam logic signed [15:0] Z_ONE =
    (AXIS_FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << AXIS_FRAC_BITS);

  // hamilton product current * increment, four terms per part (w, x, y, z)
  function automatic ham_t ham_term(input logic [3:0] j);
    ham_t t;
    case (j)
      4'd0:    t = '{2'd0, 2'd0, 1'b0};
      4'd1:    t = '{2'd1, 2'd1, 1'b1};
      4'd2:    t = '{2'd2, 2'd2, 1'b1};
      4'd3:    t = '{2'd3, 2'd3, 1'b1};
      4'd4:    t = '{2'd0, 2'd1, 1'b0};
      4'd5:    t = '{2'd1, 2'd0, 1'b0};
      4'd6:    t = '{2'd2, 2'd3, 1'b0};
      4'd7:    t = '{2'd3, 2'd2, 1'b1};
      4'd8:    t = '{2'd0, 2'd2, 1'b0};
      4'd9:    t = '{2'd1, 2'd3, 1'b1};
      4'd10:   t = '{2'd2, 2'd0, 1'b0};
      4'd11:   t = '{2'd3, 2'd1, 1'b0};
      4'd12:   t = '{2'd0, 2'd3, 1'b0};
      4'd13:   t = '{2'd1, 2'd2, 1'b0};
      4'd14:   t = '{2'd2, 2'd1, 1'b1};
      4'd15:   t = '{2'd3, 2'd0, 1'b0};
      default: t = '{2'd0, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AW-1:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [QW-1:0] sx16(input logic [15:0] v);
    return $signed({{(QW-16){v[15]}}, v});
  endfunction

  // control
  state_e            st_q;
  pass_e             pass_q;
  logic [5:0]        cnt_q;
  logic              m_valid_q;
  logic signed [15:0] cur_q [3];
  logic signed [15:0] cur_ang_q;
  logic              bad_out_q;

  // datapath
  logic signed [QW-1:0] vec_q [3];
  logic signed [QW-1:0] n_q [3];
  logic signed [QW-1:0] qa_q [4];
  logic signed [QW-1:0] qb_q [4];
  logic signed [QW-1:0] sin_q;
  logic signed [QW-1:0] w_q;
  logic [15:0]          stp_q [3];
  logic [15:0]          stp_ang_q;
  logic signed [15:0]   res_q [3];
  logic signed [15:0]   res_ang_q;
  logic [63:0]          acc_q;
  logic [63:0]          rad_q;
  logic [63:0]          root_q;
  logic signed [67:0]   prod_q;
  logic                 neg_q;
  logic                 flip_q;
  logic                 bad_q;

  // shared multiplier operands and helpers
  logic signed [QW-1:0] mul_a, mul_b;
  logic [1:0]           idx;
  ham_t                 term;
  logic                 vec_zero;
  logic [63:0]          bitv, trial;
  logic [QW-1:0]        vmag;
  logic [63:0]          dividend;
  logic [63:0]          ham_sum;
  logic [2:0]           ham_k;
  logic signed [15:0]   ang_sel;
  logic signed [AW-1:0] th, th_fold;
  logic                 th_flip;
  logic signed [AW-1:0] cx0, cy0, cz0;
  logic signed [AW-1:0] cx, cy, cz, ang_rnd;
  logic signed [QW-1:0] cos_v, sin_v;
  logic                 div_start, div_done;
  logic signed [QW-1:0] div_q;
  cordic_cmd_t          cmd;
  logic                 cdone;

  assign idx      = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
  assign term     = ham_term(cnt_q[3:0]);
  assign vec_zero = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_NSQ: begin
        mul_a = vec_q[idx];
        mul_b = vec_q[idx];
      end
      S_SCL: begin
        mul_a = n_q[idx];
        mul_b = sin_q;
      end
      S_HAM: begin
        mul_a = qa_q[term.i1];
        mul_b = qb_q[term.i2];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root, one result bit per cycle
  assign bitv  = 64'd1 << (6'd62 - {cnt_q[4:0], 1'b0});
  assign trial = root_q + bitv;

  // divider operands: |v| scaled to Q30 of the length, or to the output format
  assign vmag     = vec_q[idx][QW-1] ? QW'(-vec_q[idx]) : QW'(vec_q[idx]);
  assign dividend = (pass_q == P_OUT) ? (64'(vmag) << AXIS_FRAC_BITS) : (64'(vmag) << 45);
  assign div_start = (st_q == S_NDIV_GO);

  aarc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (root_q[31:0]),
    .neg_i      (vec_q[idx][QW-1]),
    .quot_o     (div_q),
    .done_o     (div_done)
  );

  // mac for one hamilton part, closed every fourth term
  assign ham_sum = neg_q ? (acc_q - prod_q[63:0]) : (acc_q + prod_q[63:0]);
  assign ham_k   = cnt_q[4:2] - 3'd1;

  // half angle in Q30, folded by pi into about +-pi/2
  assign ang_sel = (pass_q == P_CUR) ? cur_ang_q : $signed(stp_ang_q);
  assign th      = $signed({{(AW-16){ang_sel[15]}}, ang_sel}) <<< 17;
  always_comb begin
    th_fold = th;
    th_flip = 1'b0;
    if (th > HALF_PI_Q30) begin
      th_fold = th - PI_Q30;
      th_flip = 1'b1;
    end else if (th < -HALF_PI_Q30) begin
      th_fold = th + PI_Q30;
      th_flip = 1'b1;
    end
  end

  always_comb begin
    cmd.load = (st_q == S_TRIG) || (st_q == S_ATAN);
    cmd.mode = (st_q == S_TRIG) ? CM_ROTATE : CM_VECTOR;
    if (st_q == S_TRIG) begin
      cx0 = GAIN_Q30;
      cy0 = '0;
      cz0 = th_fold;
    end else if (w_q[QW-1]) begin
      // real part negative: start a quarter turn ahead
      cx0 = $signed({4'b0000, root_q[31:0]});
      cy0 = -$signed({{(AW-QW){w_q[QW-1]}}, w_q});
      cz0 = HALF_PI_Q30;
    end else begin
      cx0 = $signed({{(AW-QW){w_q[QW-1]}}, w_q});
      cy0 = $signed({4'b0000, root_q[31:0]});
      cz0 = '0;
    end
  end

  aarc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (cx0),
    .y_i    (cy0),
    .z_i    (cz0),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz),
    .done_o (cdone)
  );

  assign cos_v   = flip_q ? -cx[QW-1:0] : cx[QW-1:0];
  assign sin_v   = flip_q ? -cy[QW-1:0] : cy[QW-1:0];
  assign ang_rnd = (cz + 36'sd65536) >>> 17;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      pass_q    <= P_CUR;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      cur_q[0]  <= 16'sd0;
      cur_q[1]  <= 16'sd0;
      cur_q[2]  <= 16'sd16384;
      cur_ang_q <= 16'sd0;
      bad_out_q <= 1'b0;
    end else begin
      // the done state refills the output register itself
      if (m_valid_q && m_axis_tready && (st_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pass_q <= P_CUR;
            cnt_q  <= '0;
            st_q   <= S_NSQ;
          end
        end
        S_NSQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            st_q <= S_NCHK;
          end
        end
        S_NCHK: begin
          cnt_q <= '0;
          if (!vec_zero) begin
            st_q <= S_NSQRT;
          end else if (pass_q == P_CUR) begin
            st_q <= S_TRIG;
          end else if (pass_q == P_STEP) begin
            st_q <= S_HAM;
          end else begin
            st_q <= S_DONE;
          end
        end
        S_NSQRT: begin
          if (cnt_q == 6'd31) begin
            cnt_q <= '0;
            st_q  <= S_NDIV_GO;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_NDIV_GO: begin
          st_q <= S_NDIV_WAIT;
        end
        S_NDIV_WAIT: begin
          if (div_done) begin
            if (cnt_q == 6'd2) begin
              cnt_q <= '0;
              st_q  <= (pass_q == P_OUT) ? S_ATAN : S_TRIG;
            end else begin
              cnt_q <= cnt_q + 6'd1;
              st_q  <= S_NDIV_GO;
            end
          end
        end
        S_TRIG: begin
          st_q <= S_TRIG_WAIT;
        end
        S_TRIG_WAIT: begin
          if (cdone) begin
            cnt_q <= '0;
            st_q  <= S_SCL;
          end
        end
        S_SCL: begin
          if (cnt_q == 6'd3) begin
            cnt_q <= '0;
            if (pass_q == P_CUR) begin
              pass_q <= P_STEP;
              st_q   <= S_NSQ;
            end else begin
              st_q <= S_HAM;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_HAM: begin
          if (cnt_q == 6'd16) begin
            cnt_q  <= '0;
            pass_q <= P_OUT;
            st_q   <= S_NSQ;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_ATAN: begin
          st_q <= S_ATAN_WAIT;
        end
        S_ATAN_WAIT: begin
          if (cdone) begin
            st_q <= S_DONE;
          end
        end
        S_DONE: begin
          // the output register is free or empties this cycle
          if (!m_valid_q || m_axis_tready) begin
            cur_q[0]  <= res_q[0];
            cur_q[1]  <= res_q[1];
            cur_q[2]  <= res_q[2];
            cur_ang_q <= res_ang_q;
            bad_out_q <= bad_q;
            m_valid_q <= 1'b1;
            st_q      <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    neg_q  <= term.neg;
    case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          stp_q[0]  <= s_axis_tdata[15:0];
          stp_q[1]  <= s_axis_tdata[31:16];
          stp_q[2]  <= s_axis_tdata[47:32];
          stp_ang_q <= s_axis_tdata[63:48];
          vec_q[0]  <= sx16(cur_q[0]);
          vec_q[1]  <= sx16(cur_q[1]);
          vec_q[2]  <= sx16(cur_q[2]);
          bad_q     <= 1'b0;
        end
      end
      S_NSQ: begin
        acc_q <= (cnt_q == 6'd0) ? 64'd0 : acc_q + prod_q[63:0];
      end
      S_NCHK: begin
        rad_q  <= (pass_q == P_OUT) ? acc_q : (acc_q << 30);
        root_q <= '0;
        acc_q  <= '0;
        if (vec_zero) begin
          case (pass_q)
            P_CUR: begin
              n_q[0] <= '0;
              n_q[1] <= '0;
              n_q[2] <= ONE_Q30;
            end
            P_STEP: begin
              // zero-length increment acts as the identity rotation
              bad_q   <= 1'b1;
              qb_q[0] <= ONE_Q30;
              qb_q[1] <= '0;
              qb_q[2] <= '0;
              qb_q[3] <= '0;
            end
            default: begin
              res_q[0]  <= 16'sd0;
              res_q[1]  <= 16'sd0;
              res_q[2]  <= Z_ONE;
              res_ang_q <= 16'sd0;
            end
          endcase
        end
      end
      S_NSQRT: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bitv;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      S_NDIV_WAIT: begin
        if (div_done) begin
          if (pass_q == P_OUT) begin
            res_q[idx] <= sat16($signed({{(AW-QW){div_q[QW-1]}}, div_q}));
          end else begin
            n_q[idx] <= div_q;
          end
        end
      end
      S_TRIG: begin
        flip_q <= th_flip;
      end
      S_TRIG_WAIT: begin
        if (cdone) begin
          sin_q <= sin_v;
          if (pass_q == P_CUR) begin
            qa_q[0] <= cos_v;
          end else begin
            qb_q[0] <= cos_v;
          end
        end
      end
      S_SCL: begin
        if (cnt_q != 6'd0) begin
          if (pass_q == P_CUR) begin
            qa_q[cnt_q[1:0]] <= prod_q[63:30];
          end else begin
            qb_q[cnt_q[1:0]] <= prod_q[63:30];
          end
        end
        // the increment axis is normalized next
        if ((cnt_q == 6'd3) && (pass_q == P_CUR)) begin
          vec_q[0] <= sx16(stp_q[0]);
          vec_q[1] <= sx16(stp_q[1]);
          vec_q[2] <= sx16(stp_q[2]);
        end
        acc_q <= '0;
      end
      S_HAM: begin
        if (cnt_q != 6'd0) begin
          if (cnt_q[1:0] == 2'd0) begin
            if (ham_k == 3'd0) begin
              w_q <= ham_sum[63:30];
            end else begin
              vec_q[ham_k[1:0] - 2'd1] <= ham_sum[63:30];
            end
            acc_q <= '0;
          end else begin
            acc_q <= ham_sum;
          end
        end
      end
      S_ATAN_WAIT: begin
        if (cdone) begin
          res_ang_q <= sat16(ang_rnd);
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready   = (st_q == S_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {cur_ang_q, cur_q[2], cur_q[1], cur_q[0]};
  assign m_axis_tuser[0] = bad_out_q;

  // the divider only reports while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == S_NDIV_WAIT)
    else $error("divider finished outside its wait state");

  a_cordic_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (st_q == S_TRIG_WAIT) || (st_q == S_ATAN_WAIT))
    else $error("cordic finished outside a wait state");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q == S_DONE))
    else $error("result shown without a completed item");

  a_state_held_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_DONE) && (st_q != S_IDLE) |=> $stable(cur_ang_q) && $stable(cur_q[2]))
    else $error("held rotation changed mid-item");

endmodule

`default_nettype wire

@@ hdl/aarc_div.sv @@
// bit-serial restoring divider, 64-bit magnitude by 32-bit, 32-bit quotient magnitude returned signed
`default_nettype none

module aarc_div import aarc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          dividend_i,
  input  wire logic [31:0]          divisor_i,
  input  wire logic                 neg_i,
  output logic signed [QW-1:0]      quot_o,
  output logic                      done_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic        neg_q;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic        ge;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[63:32];
      quo_q <= dividend_i[31:0];
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign quot_o = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ hdl/aarc_cordic.sv @@
// iterative cordic, one micro-rotation per cycle, rotation or vectoring mode
`default_nettype none

module aarc_cordic import aarc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cordic_cmd_t          cmd_i,
  input  wire logic signed [AW-1:0] x_i,
  input  wire logic signed [AW-1:0] y_i,
  input  wire logic signed [AW-1:0] z_i,
  output logic signed [AW-1:0]      x_o,
  output logic signed [AW-1:0]      y_o,
  output logic signed [AW-1:0]      z_o,
  output logic                      done_o
);

  localparam int CW = $clog2(STEPS + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  cordic_mode_e         mode_q;
  logic signed [AW-1:0] x_q, y_q, z_q;
  logic signed [AW-1:0] xs, ys, at;
  logic                 pos;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign at  = $signed({4'b0000, ATAN_Q30[5'(cnt_q)]});
  // rotate toward zero residual angle, or drive y toward zero
  assign pos = (mode_q == CM_ROTATE) ? ~z_q[AW-1] : (y_q <= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      mode_q <= cmd_i.mode;
    end else if (busy_q) begin
      if (pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the axis-angle rotation composer: directed and random increments, checked
// against a fixed-point predictor of the quaternion composition
`default_nettype none

module tb_top;
  import aarc_pkg::*;

  localparam int STEPS = 16;
  localparam int FRAC  = 14;
  localparam longint ONE30   = 64'sd1073741824;
  localparam longint GAIN30  = 64'sh26DD3B6A;
  localparam longint HPI30   = 64'sh6487ED51;
  localparam longint PI30    = 64'shC90FDAA2;
  localparam longint TWO_PI_Q12 = 25736;

  typedef struct {
    logic signed [15:0] ax, ay, az, ang;
    logic               bad;
  } rot_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  axis_angle_rotation_composer #(.CORDIC_STEPS(STEPS), .AXIS_FRAC_BITS(FRAC)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: the held rotation
  longint held_x, held_y, held_z, held_ang;
  rot_t   pending_rot[$];
  int     n_sent, n_recv, n_bad_axis, n_mismatch;

  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // normalize a 16-bit vector to Q30; zero length gives (0,0,1) and 0
  function automatic bit normalize(longint x, longint y, longint z,
                                   output longint nx, ny, nz);
    longint unsigned s;
    longint len;
    s = longint'(x * x) + longint'(y * y) + longint'(z * z);
    nx = 0; ny = 0; nz = ONE30;
    if (s == 0) return 0;
    len = int_sqrt(s << 30);
    nx = (x * (64'sd1 << 45)) / len;
    ny = (y * (64'sd1 << 45)) / len;
    nz = (z * (64'sd1 << 45)) / len;
    return 1;
  endfunction

  task automatic cordic_sincos(longint th, output longint c, s);
    longint x, y, nx;
    bit flip;
    x = GAIN30; y = 0; flip = 0;
    if (th > HPI30) begin
      th -= PI30; flip = 1;
    end else if (th < -HPI30) begin
      th += PI30; flip = 1;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (th >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); th -= longint'(ATAN_Q30[i]);
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); th += longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, nx, t;
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = HPI30;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (y > 0) begin
        nx = x + sra(y, i); y = y - sra(x, i); z += longint'(ATAN_Q30[i]);
      end else begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  // compose held rotation with the increment, update held state
  task automatic compose_rotation(logic signed [15:0] sx, sy, sz, sang, output rot_t r);
    longint n1x, n1y, n1z, n2x, n2y, n2z, w1, s1, w2, s2;
    longint a1, b1, c1, a2, b2, c2, w, a, b, c, len;
    longint unsigned ss;
    bit good;
    void'(normalize(held_x, held_y, held_z, n1x, n1y, n1z));
    cordic_sincos(held_ang * (64'sd1 << 17), w1, s1);
    a1 = sra(n1x * s1, 30); b1 = sra(n1y * s1, 30); c1 = sra(n1z * s1, 30);
    good = normalize(sx, sy, sz, n2x, n2y, n2z);
    if (good) begin
      cordic_sincos(longint'(sang) * (64'sd1 << 17), w2, s2);
      a2 = sra(n2x * s2, 30); b2 = sra(n2y * s2, 30); c2 = sra(n2z * s2, 30);
    end else begin
      w2 = ONE30; a2 = 0; b2 = 0; c2 = 0;
    end
    w = sra(w1 * w2 - a1 * a2 - b1 * b2 - c1 * c2, 30);
    a = sra(w1 * a2 + a1 * w2 + b1 * c2 - c1 * b2, 30);
    b = sra(w1 * b2 - a1 * c2 + b1 * w2 + c1 * a2, 30);
    c = sra(w1 * c2 + a1 * b2 - b1 * a2 + c1 * w2, 30);
    if (a == 0 && b == 0 && c == 0) begin
      held_x = 0; held_y = 0; held_z = sat16(64'sd1 << FRAC); held_ang = 0;
    end else begin
      ss = longint'(a * a) + longint'(b * b) + longint'(c * c);
      len = int_sqrt(ss);
      held_x = sat16((a * (64'sd1 << FRAC)) / len);
      held_y = sat16((b * (64'sd1 << FRAC)) / len);
      held_z = sat16((c * (64'sd1 << FRAC)) / len);
      held_ang = sat16(sra(cordic_atan2(len, w) + (64'sd1 << 16), 17));
    end
    r.ax = held_x[15:0]; r.ay = held_y[15:0]; r.az = held_z[15:0];
    r.ang = held_ang[15:0]; r.bad = !good;
  endtask

  // send one increment, predict its result once accepted; tvalid stays high into
  // the next item when its random gap is zero
  task automatic send_step(logic signed [15:0] sx, sy, sz, sang);
    rot_t r;
    int   gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {sang, sz, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    compose_rotation(sx, sy, sz, sang, r);
    pending_rot.push_back(r);
    n_sent++;
    if (r.bad) n_bad_axis++;
  endtask

  // receiver: a random wait with tready low before each transfer
  initial begin
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 3);
      if (wait_n != 0) begin
        m_axis_tready <= 0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
    end
  end

  // result checker
  initial begin
    rot_t e;
    logic [63:0] got;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_rot.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transfer: data %h", got);
        end else begin
          e = pending_rot.pop_front();
          n_recv++;
          if (got[15:0] !== e.ax || got[31:16] !== e.ay || got[47:32] !== e.az ||
              got[63:48] !== e.ang || m_axis_tuser[0] !== e.bad) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch #%0d: exp x %0d y %0d z %0d ang %0d bad %0d;",
                       n_recv, e.ax, e.ay, e.az, e.ang, e.bad,
                       "  got x %0d y %0d z %0d ang %0d bad %0d",
                       $signed(got[15:0]), $signed(got[31:16]), $signed(got[47:32]),
                       $signed(got[63:48]), m_axis_tuser[0]);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_step(0, 0, 16384, 0);
    send_step(16384, 0, 0, 6434);
    send_step(0, 0, 0, 1000);
    send_step(0, 0, 0, 0);
    send_step(32767, 32767, 32767, 25736);
    send_step(-32768, -32768, -32768, -25736);
    send_step(-32768, 0, 0, -32768);
    send_step(32767, 0, 0, 32767);
    send_step(0, 1, 0, 12868);
    send_step(0, -1, 0, -12868);
    send_step(1, 0, 0, 6435);
    send_step(0, 0, -16384, 25736);
    send_step(16384, 16384, 0, 12868);
    send_step(16384, 16384, 0, -12868);
    send_step(-1, -1, -1, 1);
    send_step(0, 0, 16384, 12867);
    send_step(0, 0, 16384, 12869);
    send_step(0, 0, 16384, -12869);
  endtask

  task automatic test_random_steps(int count);
    logic signed [15:0] v[4];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0: v[k] = 16'sd0;
          1: v[k] = 16'($urandom_range(0, 7) - 4);
          default: v[k] = 16'($urandom);
        endcase
      end
      if ($urandom_range(0, 49) == 0) begin
        v[0] = 16'sd0; v[1] = 16'sd0; v[2] = 16'sd0;
      end
      case ($urandom_range(0, 7))
        0: v[3] = 16'($urandom);
        1: v[3] = 16'($urandom_range(0, 8) - 4);
        default: v[3] = 16'(longint'($urandom_range(0, 2 * TWO_PI_Q12)) - TWO_PI_Q12);
      endcase
      send_step(v[0], v[1], v[2], v[3]);
    end
  endtask

  initial begin
    held_x = 0; held_y = 0; held_z = 16384; held_ang = 0;
    n_sent = 0; n_recv = 0; n_bad_axis = 0; n_mismatch = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_random_steps(2000);
    s_axis_tvalid <= 0;
    while (pending_rot.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("composed %0d increments, %0d results checked, %0d with a zero-length axis",
             n_sent, n_recv, n_bad_axis);
    if (n_mismatch == 0 && pending_rot.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit: ~2020 items with stalls, several times over
  initial begin
    #60000000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
